[rtl/rms_pkg.sv]
// Package for the RMS-of-sample-block design: sizes, limits, state types and
// the control structs between the top level and the divide/root unit.
// Depends on nothing.
package rms_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int IN_W    = 16;
  localparam int RMS_W   = 15;
  localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W   = SQ_W + $clog2(MAX_SAMPLES);
  localparam int ROOT_W  = SAMPLE_BITS;
  localparam int REM_W   = COUNT_W + 1;
  localparam int ALU_W   = SQ_W + 1;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic [RMS_W-1:0] RMS_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_CALC,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_DIV,
    CORE_ROOT
  } core_state_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } core_in_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } core_out_t;

endpackage

[rtl/rms_if.sv]
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on rms_pkg for the field widths.
interface rms_in_if import rms_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] sample;
  logic            last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface rms_out_if import rms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms_value;
  logic             no_samples;
  logic             overflowed;

  modport source (output valid, output rms_value, output no_samples, output overflowed,
                  input ready);
  modport sink (input valid, input rms_value, input no_samples, input overflowed,
                output ready);
endinterface

[rtl/rms_of_sample_block.sv]
// Top level of the RMS-of-sample-block design: squares and sums the samples
// of a block and reports the root of their mean. Depends on rms_pkg, the
// channel interfaces in rms_if and the divide/root unit rms_divroot.
//
// Usage: samples arrive on the samples channel, one per transfer, as signed
// Q3.12 values; last_sample marks the final sample of a block. Each sample is
// squared in the cycle of its transfer and added to a running sum in the next.
// Non-final samples are taken one per cycle. After the final sample the
// block holds ready low while it divides the sum by the count and takes the
// square root, one bit per cycle on one shared subtractor. When the block
// counted nothing, both steps are skipped. The result then waits until
// the output register is free; the next block starts once the result
// is in the output register.
// Beyond MAX_SAMPLES samples the rest of a block is dropped and the result
// carries the overflowed flag. The result stays in its register until the
// results channel takes it; a stalled receiver delays only the next result
// and the samples of later blocks. Reset clears the sum, count and all valid flags.
module rms_of_sample_block import rms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rms_in_if.sink    samples,
  rms_out_if.source results
);

  state_t             state, state_next;
  logic [SUM_W-1:0]   square_sum, square_sum_next;
  logic [COUNT_W-1:0] sample_count, sample_count_next;
  logic               saturated_mark, saturated_mark_next;
  logic [SQ_W-1:0]    square_reg, square_reg_next;
  logic [ROOT_W-1:0]  root_hold, root_hold_next;
  logic               empty_hold, empty_hold_next;
  logic               ovf_hold, ovf_hold_next;
  logic               out_valid, out_valid_next;
  logic [RMS_W-1:0]   rms_reg, rms_reg_next;
  logic               empty_reg, empty_reg_next;
  logic               ovf_reg, ovf_reg_next;

  logic [SAMPLE_BITS-1:0]   raw;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] product;
  logic [SUM_W-1:0]         sum_add;
  logic                     accept_in;
  logic                     load_out;
  core_in_t                 core_in;
  core_out_t                core_out;

  rms_divroot u_divroot (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (core_in),
    .ctl_out (core_out)
  );

  assign raw       = samples.sample[SAMPLE_BITS-1:0];
  assign mag       = raw[SAMPLE_BITS-1] ? (~raw) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1} : raw;
  assign product   = mag * mag;
  assign sum_add   = square_sum + SUM_W'(square_reg);
  assign accept_in = samples.valid && samples.ready;

  always_comb begin
    state_next          = state;
    square_sum_next     = sum_add;
    sample_count_next   = sample_count;
    saturated_mark_next = saturated_mark;
    square_reg_next     = '0;
    root_hold_next      = root_hold;
    empty_hold_next     = empty_hold;
    ovf_hold_next       = ovf_hold;
    load_out            = 1'b0;
    core_in.start       = 1'b0;
    core_in.dividend    = sum_add;
    core_in.divisor     = sample_count;
    samples.ready       = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          if (sample_count == COUNT_W'(MAX_SAMPLES)) begin
            saturated_mark_next = 1'b1;
          end else begin
            sample_count_next = sample_count + COUNT_W'(1);
            square_reg_next   = product[SQ_W-1:0];
          end
          if (samples.last_sample) begin
            state_next = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        core_in.start       = (sample_count != '0);
        empty_hold_next     = (sample_count == '0);
        ovf_hold_next       = saturated_mark;
        root_hold_next      = '0;
        square_sum_next     = '0;
        sample_count_next   = '0;
        saturated_mark_next = 1'b0;
        state_next          = (sample_count == '0) ? ST_FIN : ST_CALC;
      end
      ST_CALC: begin
        if (core_out.done) begin
          root_hold_next = core_out.root;
          state_next     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = load_out || (out_valid && !results.ready);
    rms_reg_next   = rms_reg;
    empty_reg_next = empty_reg;
    ovf_reg_next   = ovf_reg;
    if (load_out) begin
      rms_reg_next   = (root_hold > ROOT_W'(RMS_MAX)) ? RMS_MAX : RMS_W'(root_hold);
      empty_reg_next = empty_hold;
      ovf_reg_next   = ovf_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      square_sum     <= '0;
      sample_count   <= '0;
      saturated_mark <= 1'b0;
      square_reg     <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      square_sum     <= square_sum_next;
      sample_count   <= sample_count_next;
      saturated_mark <= saturated_mark_next;
      square_reg     <= square_reg_next;
      out_valid      <= out_valid_next;
    end
    root_hold  <= root_hold_next;
    empty_hold <= empty_hold_next;
    ovf_hold   <= ovf_hold_next;
    rms_reg    <= rms_reg_next;
    empty_reg  <= empty_reg_next;
    ovf_reg    <= ovf_reg_next;
  end

  assign results.valid      = out_valid;
  assign results.rms_value  = rms_reg;
  assign results.no_samples = empty_reg;
  assign results.overflowed = ovf_reg;

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    sample_count <= COUNT_W'(MAX_SAMPLES))
    else $error("sample count exceeded its limit");

  a_empty_clear: assert property (@(posedge clk) disable iff (rst)
    sample_count == '0 |-> (square_sum == '0 && square_reg == '0))
    else $error("sum of squares not clear while no sample is counted");

  a_last_acc: assert property (@(posedge clk) disable iff (rst)
    accept_in && samples.last_sample |=> state == ST_ACC)
    else $error("final sample transfer did not close the block");

  a_done_calc: assert property (@(posedge clk) disable iff (rst)
    core_out.done |-> state == ST_CALC)
    else $error("root finished outside the calculation state");

  a_result_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result became valid without a finished calculation");

endmodule

[rtl/rms_divroot.sv]
// Iterative divide and square root unit: one restoring divide step and then
// one square root digit per cycle, both on a single shared subtractor.
// Depends on rms_pkg.
module rms_divroot import rms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  core_in_t  ctl_in,
  output core_out_t ctl_out
);

  core_state_t        state, state_next;
  logic [SUM_W-1:0]   q, q_next;
  logic [REM_W-1:0]   rem, rem_next;
  logic [COUNT_W-1:0] divisor, divisor_next;
  logic [STEP_W-1:0]  step, step_next;
  logic [SQ_W-1:0]    v, v_next;
  logic [SQ_W-1:0]    res, res_next;
  logic [SQ_W-1:0]    bitm, bitm_next;
  logic               done, done_next;
  logic [ROOT_W-1:0]  root, root_next;

  logic [REM_W-1:0]   rem_sh;
  logic [ALU_W-1:0]   alu_a, alu_b;
  logic [ALU_W:0]     alu_diff;
  logic               alu_ge;

  assign rem_sh   = {rem[REM_W-2:0], q[SUM_W-1]};
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = ~alu_diff[ALU_W];

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state)
      CORE_DIV: begin
        alu_a = ALU_W'(rem_sh);
        alu_b = ALU_W'(divisor);
      end
      CORE_ROOT: begin
        alu_a = ALU_W'(v);
        alu_b = ALU_W'(res | bitm);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    q_next       = q;
    rem_next     = rem;
    divisor_next = divisor;
    step_next    = step;
    v_next       = v;
    res_next     = res;
    bitm_next    = bitm;
    done_next    = 1'b0;
    root_next    = root;
    case (state)
      CORE_IDLE: begin
        if (ctl_in.start) begin
          q_next       = ctl_in.dividend;
          divisor_next = ctl_in.divisor;
          rem_next     = '0;
          step_next    = '0;
          state_next   = CORE_DIV;
        end
      end
      CORE_DIV: begin
        if (alu_ge) begin
          rem_next = alu_diff[REM_W-1:0];
          q_next   = {q[SUM_W-2:0], 1'b1};
        end else begin
          rem_next = rem_sh;
          q_next   = {q[SUM_W-2:0], 1'b0};
        end
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(SUM_W - 1)) begin
          v_next     = q_next[SQ_W-1:0];
          res_next   = '0;
          bitm_next  = {1'b1, {(SQ_W-1){1'b0}}};
          state_next = CORE_ROOT;
        end
      end
      CORE_ROOT: begin
        if (alu_ge) begin
          v_next   = alu_diff[SQ_W-1:0];
          res_next = (res >> 1) | bitm;
        end else begin
          res_next = res >> 1;
        end
        bitm_next = bitm >> 2;
        if (bitm[0]) begin
          done_next  = 1'b1;
          root_next  = res_next[ROOT_W-1:0];
          state_next = CORE_IDLE;
        end
      end
      default: begin
        state_next = CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    q       <= q_next;
    rem     <= rem_next;
    divisor <= divisor_next;
    step    <= step_next;
    v       <= v_next;
    res     <= res_next;
    bitm    <= bitm_next;
    root    <= root_next;
  end

  assign ctl_out.done = done;
  assign ctl_out.root = root;

endmodule

[tb/testbench.sv]
// Testbench for rms_of_sample_block: drives blocks of Q3.12 samples, predicts
// each block's root mean square and checks every result transfer against it.
// Depends on rms_pkg, the channel interfaces in rms_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import rms_pkg::*;

  typedef struct {
    logic [RMS_W-1:0] rms;
    logic             empty;
    logic             ovf;
  } rms_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b0;
  int   mismatches = 0;

  logic [63:0] acc_sum = '0;
  int          acc_count = 0;
  logic        acc_saturated = 1'b0;
  rms_result_t expected_rms[$];

  rms_in_if  samples_ch ();
  rms_out_if results_ch ();

  rms_of_sample_block i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch)
  );

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) begin
        r = trial;
      end
    end
    return r;
  endfunction

  function automatic void accumulate_sample(input logic [IN_W-1:0] s, input logic is_last);
    logic [IN_W:0] mag;
    logic [63:0]   root;
    rms_result_t   r;
    mag = s[IN_W-1] ? ({1'b0, ~s} + 1'b1) : {1'b0, s};
    if (acc_count >= MAX_SAMPLES) begin
      acc_saturated = 1'b1;
    end else begin
      acc_sum += 64'(mag) * 64'(mag);
      acc_count++;
    end
    if (is_last) begin
      r.rms   = '0;
      r.empty = (acc_count == 0);
      r.ovf   = acc_saturated;
      if (acc_count != 0) begin
        root = floor_sqrt(acc_sum / 64'(acc_count));
        r.rms = (root > 64'(RMS_MAX)) ? RMS_MAX : root[RMS_W-1:0];
      end
      expected_rms.push_back(r);
      acc_sum       = '0;
      acc_count     = 0;
      acc_saturated = 1'b0;
    end
  endfunction

  always @(negedge clk) begin
    results_ch.ready = steady || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin : check_results
    rms_result_t exp_r;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (expected_rms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: rms_value=%0d no_samples=%0b overflowed=%0b",
                   results_ch.rms_value, results_ch.no_samples, results_ch.overflowed);
        end
      end else begin
        exp_r = expected_rms.pop_front();
        if (results_ch.rms_value !== exp_r.rms || results_ch.no_samples !== exp_r.empty ||
            results_ch.overflowed !== exp_r.ovf) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected rms_value=%0d no_samples=%0b overflowed=%0b, got %0d %0b %0b",
                     exp_r.rms, exp_r.empty, exp_r.ovf, results_ch.rms_value,
                     results_ch.no_samples, results_ch.overflowed);
          end
        end
      end
    end
  end

  task automatic send_sample(input logic [IN_W-1:0] s, input logic is_last);
    while (!steady && $urandom_range(99) < 27) begin
      samples_ch.valid = 1'b0;
      @(negedge clk);
    end
    samples_ch.valid       = 1'b1;
    samples_ch.sample      = s;
    samples_ch.last_sample = is_last;
    do @(posedge clk); while (!samples_ch.ready);
    accumulate_sample(s, is_last);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    samples_ch.valid = 1'b0;
    while (expected_rms.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic test_single_sample_blocks();
    logic [IN_W-1:0] values[8];
    values = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h4000, 16'h5555,
               16'hAAAA};
    foreach (values[i]) begin
      send_sample(values[i], 1'b1);
    end
    wait_drained();
  endtask

  task automatic test_short_blocks();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0002, 1'b0);
    send_sample(16'h0003, 1'b0);
    send_sample(16'hFFFC, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h1000, 1'b0);
    send_sample(16'hF000, 1'b0);
    send_sample(16'h0800, 1'b1);
    wait_drained();
  endtask

  task automatic test_overflow_block();
    for (int i = 1; i <= MAX_SAMPLES + 5; i++) begin
      send_sample(IN_W'($urandom), i == MAX_SAMPLES + 5);
    end
    wait_drained();
  endtask

  task automatic test_random_blocks();
    int sent;
    int block_len;
    int pick;
    logic [IN_W-1:0] s;
    logic drained_once;
    sent = 0;
    drained_once = 1'b0;
    while (sent < 300) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        block_len = $urandom_range(16, 1);
      end else begin
        block_len = $urandom_range(80, 17);
      end
      for (int i = 1; i <= block_len; i++) begin
        steady = (sent >= 100 && sent < 220);
        pick = $urandom_range(99);
        if (pick < 65) begin
          s = IN_W'($urandom);
        end else if (pick < 80) begin
          s = IN_W'($signed($urandom_range(64)) - 32);
        end else if (pick < 90) begin
          s = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
        end else begin
          s = IN_W'($urandom_range(16'hFFFF, 16'hF000));
        end
        send_sample(s, i == block_len);
        sent++;
      end
      if ((!drained_once && sent >= 150) || $urandom_range(19) == 0) begin
        wait_drained();
        drained_once = 1'b1;
      end
    end
    steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    samples_ch.valid       = 1'b0;
    samples_ch.sample      = '0;
    samples_ch.last_sample = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_sample_blocks();
    test_short_blocks();
    test_overflow_block();
    test_random_blocks();

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_rms.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
